// ===== sv/mmte_pkg.sv =====
// Shared types and constants for the Mueller-Muller timing error detector.
// No dependencies; imported by every module of the block.
package mmte_pkg;

  localparam int PT_W        = 16;  // Q1.14 constellation coordinate
  localparam int ERR_W       = 34;  // Q5.28 timing error
  localparam int ERR_FRAC    = 28;
  localparam int IDX_W       = 2;
  localparam int NUM_CPOINTS = 4;
  localparam int LINE_DEPTH  = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CNT_W       = 3;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_REVERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic {
    MODE_PLAIN    = 1'b0,
    MODE_MODIFIED = 1'b1
  } mode_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT3 = 3'd5;

  localparam mode_e                  MODE_RST   = MODE_MODIFIED;
  localparam logic [CNT_W-1:0]       COUNT_RST  = 3'd2;
  localparam logic [CFG_DATA_W-1:0]  POINT0_RST = 32'h4000_0000;
  localparam logic [CFG_DATA_W-1:0]  POINT1_RST = 32'hC000_0000;
  localparam logic [CFG_DATA_W-1:0]  POINT2_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0]  POINT3_RST = 32'h0000_0000;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e cmd;
    logic real_only;
  } op_t;

endpackage

// ===== sv/mmte_front.sv =====
// Front end: two-entry input queue that classifies each command.
// Depends on mmte_pkg.
module mmte_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [1:0]                    cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  input  logic                          real_only_i,
  output logic                          full_o,
  output logic                          item_valid_o,
  output mmte_pkg::op_t                 item_o,
  output logic signed [SAMPLE_BITS-1:0] re_o,
  output logic signed [SAMPLE_BITS-1:0] im_o,
  input  logic                          take_i
);
  import mmte_pkg::*;

  op_t                          op_q [2];
  logic signed [SAMPLE_BITS-1:0] re_q [2];
  logic signed [SAMPLE_BITS-1:0] im_q [2];
  logic                         wr_q, rd_q;
  logic [1:0]                   cnt_q;
  logic                         wr_en, rd_en;
  op_t                          op_in;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = take_i && item_valid_o;

  assign op_in.cmd       = cmd_e'(cmd_i);
  assign op_in.real_only = real_only_i;

  assign item_o = op_q[rd_q];
  assign re_o   = re_q[rd_q];
  assign im_o   = im_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 2'd1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 2'd1;
    end
  end

  // real-only items carry a zero imaginary part from here on
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      op_q[wr_q] <= op_in;
      re_q[wr_q] <= sample_re_i;
      im_q[wr_q] <= real_only_i ? '0 : sample_im_i;
    end
  end

endmodule

// ===== sv/mmte_back.sv =====
// Back end: iterative slicer, shared multiply-accumulate for the error,
// delay lines and the result register. Depends on mmte_pkg.
module mmte_back #(
  parameter int MAX_POINTS  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  mmte_pkg::mode_e                                        mode_i,
  input  logic [mmte_pkg::CNT_W-1:0]                             point_count_i,
  input  logic [mmte_pkg::NUM_CPOINTS-1:0][mmte_pkg::CFG_DATA_W-1:0] points_i,
  input  logic                                                   item_valid_i,
  input  mmte_pkg::op_t                                          item_i,
  input  logic signed [SAMPLE_BITS-1:0]                          re_i,
  input  logic signed [SAMPLE_BITS-1:0]                          im_i,
  output logic                                                   take_o,
  input  logic                                                   pop_i,
  output logic                                                   res_valid_o,
  output logic signed [mmte_pkg::ERR_W-1:0]                      err_o,
  output logic [mmte_pkg::IDX_W-1:0]                             idx_o
);
  import mmte_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int DW     = ((SB > PT_W) ? SB : PT_W) + 1;
  localparam int SQ_W   = 2 * DW;
  localparam int DIST_W = SQ_W + 1;
  localparam int A_W    = SB + 1;
  localparam int B_W    = PT_W + 1;
  localparam int P_W    = A_W + B_W;
  localparam int ACC_W  = ((SB + 20) > (ERR_W + 1)) ? (SB + 20) : (ERR_W + 1);
  localparam int KW     = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);
  localparam logic signed [ACC_W-1:0] ONE_ACC =
    {{(ACC_W-ERR_FRAC-1){1'b0}}, 1'b1, {ERR_FRAC{1'b0}}};
  localparam logic signed [ACC_W-1:0] NEG_ONE_ACC = -ONE_ACC;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SL_MUL, ST_SL_CMP, ST_MAC, ST_MAC_LAST, ST_FINISH
  } state_e;

  state_e state_q;

  // delay lines, entry 0 newest
  logic signed [SB-1:0]   smp_re_q [LINE_DEPTH];
  logic signed [SB-1:0]   smp_im_q [LINE_DEPTH];
  logic signed [PT_W-1:0] dec_re_q [LINE_DEPTH];
  logic signed [PT_W-1:0] dec_im_q [LINE_DEPTH];
  logic [IDX_W-1:0]       dec_idx_q [LINE_DEPTH];
  logic signed [ERR_W-1:0] err_now_q, err_prev_q;

  // per-item working registers
  op_t                    op_q;
  logic signed [SB-1:0]   x_re_q, x_im_q;
  logic [KW-1:0]          k_q;
  logic [SQ_W-1:0]        sq_re_q, sq_im_q;
  logic [DIST_W-1:0]      best_d_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic signed [PT_W-1:0] best_re_q, best_im_q;
  logic [1:0]             t_q;
  logic signed [P_W-1:0]  prod_q;
  logic                   pneg_q, pen_q, pvld_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   res_valid_q;
  logic signed [ERR_W-1:0] res_err_q;
  logic [IDX_W-1:0]       res_idx_q;

  logic                   modified;
  logic [CFG_DATA_W-1:0]  pt_sel;
  logic signed [PT_W-1:0] p_re, p_im;
  logic signed [DW-1:0]   dr, di;
  logic signed [SQ_W-1:0] sqr_re, sqr_im;
  logic [DIST_W-1:0]      pt_dist;
  logic [CNT_W-1:0]       n_used, last_k;
  logic                   is_last, better;
  logic signed [SB-1:0]   a_x0, a_x1, a_x2;
  logic signed [PT_W-1:0] b_d0, b_d1, b_d2;
  logic signed [A_W-1:0]  op_a;
  logic signed [B_W-1:0]  op_b;
  logic signed [P_W-1:0]  prod;
  logic signed [ACC_W-1:0] term, acc_d, u_half, u_clip;
  logic signed [ERR_W-1:0] err_d;
  logic                   finish;

  assign modified = (mode_i == MODE_MODIFIED);

  // slicer datapath: each point takes a multiply state and a compare state
  assign pt_sel  = points_i[IDX_W'(k_q)];
  assign p_re    = pt_sel[CFG_DATA_W-1:PT_W];
  assign p_im    = pt_sel[PT_W-1:0];
  assign dr      = DW'(x_re_q) - DW'(p_re);
  assign di      = DW'(x_im_q) - DW'(p_im);
  assign sqr_re  = dr * dr;
  assign sqr_im  = di * di;
  assign pt_dist = DIST_W'(sq_re_q) + DIST_W'(sq_im_q);
  assign better  = (k_q == '0) || (pt_dist < best_d_q);

  assign n_used  = (point_count_i == '0) ? CNT_W'(1) :
                   ((point_count_i > MAXP) ? MAXP : point_count_i);
  assign last_k  = n_used - CNT_W'(1);
  assign is_last = (CNT_W'(k_q) == last_k);

  // error terms: t[1] picks imaginary, t[0] picks the x1-weighted term
  assign a_x0 = t_q[1] ? x_im_q      : x_re_q;
  assign a_x1 = t_q[1] ? smp_im_q[0] : smp_re_q[0];
  assign a_x2 = t_q[1] ? smp_im_q[1] : smp_re_q[1];
  assign b_d0 = t_q[1] ? best_im_q   : best_re_q;
  assign b_d1 = t_q[1] ? dec_im_q[0] : dec_re_q[0];
  assign b_d2 = t_q[1] ? dec_im_q[1] : dec_re_q[1];

  always_comb begin
    if (!t_q[0]) begin
      op_a = modified ? (A_W'(a_x0) - A_W'(a_x2)) : A_W'(a_x0);
      op_b = B_W'(b_d1);
    end else begin
      op_a = A_W'(a_x1);
      op_b = modified ? (B_W'(b_d0) - B_W'(b_d2)) : B_W'(b_d0);
    end
  end

  assign prod = op_a * op_b;

  always_comb begin
    term = '0;
    if (pvld_q && pen_q) begin
      term = pneg_q ? -ACC_W'(prod_q) : ACC_W'(prod_q);
    end
  end
  assign acc_d = acc_q + term;

  // real-only halving rounds toward minus infinity, then clip to +-1.0; both only in modified mode
  assign u_half = (modified && op_q.real_only) ? (acc_q >>> 1) : acc_q;
  always_comb begin
    u_clip = u_half;
    if (modified) begin
      if (u_half > ONE_ACC) u_clip = ONE_ACC;
      else if (u_half < NEG_ONE_ACC) u_clip = NEG_ONE_ACC;
    end
  end
  assign err_d = ERR_W'(u_clip);

  assign take_o      = (state_q == ST_IDLE) && item_valid_i;
  assign finish      = (state_q == ST_FINISH) && (!res_valid_q || pop_i);
  assign res_valid_o = res_valid_q;
  assign err_o       = res_err_q;
  assign idx_o       = res_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      t_q         <= '0;
      pvld_q      <= 1'b0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
      res_err_q   <= '0;
      res_idx_q   <= '0;
      err_now_q   <= '0;
      err_prev_q  <= '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        smp_re_q[i]  <= '0;
        smp_im_q[i]  <= '0;
        dec_re_q[i]  <= POINT0_RST[CFG_DATA_W-1:PT_W];
        dec_im_q[i]  <= POINT0_RST[PT_W-1:0];
        dec_idx_q[i] <= '0;
      end
    end else begin
      if (finish) res_valid_q <= 1'b1;
      else if (pop_i) res_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (item_valid_i) begin
            if (item_i.cmd == CMD_SAMPLE || item_i.cmd == CMD_CLEAR) begin
              state_q <= ST_SL_MUL;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_SL_MUL: state_q <= ST_SL_CMP;
        ST_SL_CMP: begin
          if (is_last) begin
            t_q    <= '0;
            pvld_q <= 1'b0;
            acc_q  <= '0;
            state_q <= (op_q.cmd == CMD_CLEAR) ? ST_FINISH : ST_MAC;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= ST_SL_MUL;
          end
        end
        ST_MAC: begin
          pvld_q <= 1'b1;
          acc_q  <= acc_d;
          t_q    <= t_q + 2'd1;
          if (t_q == 2'd3) state_q <= ST_MAC_LAST;
        end
        ST_MAC_LAST: begin
          acc_q   <= acc_d;
          pvld_q  <= 1'b0;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish) begin
            state_q <= ST_IDLE;
            case (op_q.cmd)
              CMD_SAMPLE: begin
                for (int i = LINE_DEPTH - 1; i > 0; i--) begin
                  smp_re_q[i]  <= smp_re_q[i-1];
                  smp_im_q[i]  <= smp_im_q[i-1];
                  dec_re_q[i]  <= dec_re_q[i-1];
                  dec_im_q[i]  <= dec_im_q[i-1];
                  dec_idx_q[i] <= dec_idx_q[i-1];
                end
                smp_re_q[0]  <= x_re_q;
                smp_im_q[0]  <= x_im_q;
                dec_re_q[0]  <= best_re_q;
                dec_im_q[0]  <= best_im_q;
                dec_idx_q[0] <= best_idx_q;
                err_prev_q   <= err_now_q;
                err_now_q    <= err_d;
                res_err_q    <= err_d;
                res_idx_q    <= best_idx_q;
              end
              CMD_REVERT: begin
                // plain mode keeps a two-deep line: older and oldest stay put
                smp_re_q[0]  <= smp_re_q[1];
                smp_im_q[0]  <= smp_im_q[1];
                dec_re_q[0]  <= dec_re_q[1];
                dec_im_q[0]  <= dec_im_q[1];
                dec_idx_q[0] <= dec_idx_q[1];
                if (modified) begin
                  smp_re_q[1]  <= smp_re_q[2];
                  smp_im_q[1]  <= smp_im_q[2];
                  dec_re_q[1]  <= dec_re_q[2];
                  dec_im_q[1]  <= dec_im_q[2];
                  dec_idx_q[1] <= dec_idx_q[2];
                end
                err_now_q <= err_prev_q;
                res_err_q <= err_prev_q;
                res_idx_q <= dec_idx_q[1];
              end
              CMD_CLEAR: begin
                for (int i = 0; i < LINE_DEPTH; i++) begin
                  smp_re_q[i]  <= '0;
                  smp_im_q[i]  <= '0;
                  dec_re_q[i]  <= best_re_q;
                  dec_im_q[i]  <= best_im_q;
                  dec_idx_q[i] <= best_idx_q;
                end
                err_now_q  <= '0;
                err_prev_q <= '0;
                res_err_q  <= '0;
                res_idx_q  <= best_idx_q;
              end
              default: begin
                res_err_q <= err_now_q;
                res_idx_q <= dec_idx_q[0];
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      op_q   <= item_i;
      x_re_q <= (item_i.cmd == CMD_CLEAR) ? '0 : re_i;
      x_im_q <= (item_i.cmd == CMD_CLEAR) ? '0 : im_i;
    end
    if (state_q == ST_SL_MUL) begin
      sq_re_q <= sqr_re;
      sq_im_q <= sqr_im;
    end
    if (state_q == ST_SL_CMP && better) begin
      best_d_q   <= pt_dist;
      best_idx_q <= IDX_W'(k_q);
      best_re_q  <= p_re;
      best_im_q  <= p_im;
    end
    if (state_q == ST_MAC) begin
      prod_q <= prod;
      pneg_q <= t_q[0];
      pen_q  <= !(op_q.real_only && t_q[1]);
    end
  end

endmodule

// ===== sv/mueller_muller_timing_error.sv =====
// Mueller-Muller timing error detector: command queue (input side), one
// sequenced error engine with a result register (output side).
//
// Input channel: push/full queue; cmd 0 takes a sample, 1 reverts the last
// sample, 2 clears the delay lines (decisions load the slice of zero), 3 does
// nothing. Every accepted item gives exactly one result.
// Result channel: empty/pop queue carrying timing_error_o (Q5.28) and
// decision_index_o of the newest stored sample.
// Config channel: cfg_valid_i/cfg_ready_o, always ready; write only when idle.
// For a sample the slicer visits each point in use in a multiply state and a
// compare state, and the error needs four passes through one multiplier.
// The two-entry input queue keeps taking items while a result waits; if pop
// stays low the engine holds its finished item until the result register
// frees. Reset empties both queues, loads the reset registers and leaves the
// decisions at point 0 with zero samples and errors.
module mueller_muller_timing_error #(
  parameter int MAX_POINTS  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_im_i,
  input  logic                                 real_only_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [mmte_pkg::ERR_W-1:0]    timing_error_o,
  output logic [mmte_pkg::IDX_W-1:0]           decision_index_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mmte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mmte_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mmte_pkg::*;

  mode_e                                    mode_q;
  logic [CNT_W-1:0]                         count_q;
  logic [NUM_CPOINTS-1:0][CFG_DATA_W-1:0]   point_q;

  logic                         item_valid, take, res_valid;
  op_t                          item;
  logic signed [SAMPLE_BITS-1:0] item_re, item_im;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RST;
      count_q    <= COUNT_RST;
      point_q[0] <= POINT0_RST;
      point_q[1] <= POINT1_RST;
      point_q[2] <= POINT2_RST;
      point_q[3] <= POINT3_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:   mode_q     <= mode_e'(cfg_data_i[0]);
        REG_COUNT:  count_q    <= cfg_data_i[CNT_W-1:0];
        REG_POINT0: point_q[0] <= cfg_data_i;
        REG_POINT1: point_q[1] <= cfg_data_i;
        REG_POINT2: point_q[2] <= cfg_data_i;
        REG_POINT3: point_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mmte_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd_i),
    .sample_re_i  (sample_re_i),
    .sample_im_i  (sample_im_i),
    .real_only_i  (real_only_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .re_o         (item_re),
    .im_o         (item_im),
    .take_i       (take)
  );

  mmte_back #(
    .MAX_POINTS (MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .point_count_i (count_q),
    .points_i      (point_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .re_i          (item_re),
    .im_i          (item_im),
    .take_o        (take),
    .pop_i         (pop),
    .res_valid_o   (res_valid),
    .err_o         (timing_error_o),
    .idx_o         (decision_index_o)
  );

  assign empty = !res_valid;

endmodule

// ===== sv/mmte_checker.sv =====
// Port-level checks for the timing error detector, bound to the top level.
// Depends on mmte_pkg and mueller_muller_timing_error.
module mmte_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              push,
  input logic                              full,
  input logic                              pop,
  input logic                              empty,
  input logic signed [mmte_pkg::ERR_W-1:0] timing_error_o,
  input logic [mmte_pkg::IDX_W-1:0]        decision_index_o
);
  import mmte_pkg::*;

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty in reset");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(timing_error_o)
                          && $stable(decision_index_o)))
    else $error("result changed while stalled");

  // the input queue can only fill on a transaction
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

endmodule

bind mueller_muller_timing_error mmte_checker u_mmte_checker (.*);
